FILE: rtl/core/vrt_pkg.sv
// Shared constants, command and status types and the cell occupancy test.
package vrt_pkg;

   localparam int STEP_LIMIT_DEF = 64;
   // Cell index width: 12 bits from the origin plus room for up to 2048 steps.
   localparam int CELL_W  = 13;
   localparam int SIDE_W  = 63;
   localparam int DELTA_W = 41;
   localparam int DVD_W   = 63;
   localparam int DVS_W   = 32;
   localparam int PROD_W  = 53;
   localparam int HIT_W   = 65;
   localparam int DIFF_W  = 31;

   localparam logic [SIDE_W-1:0] SIDE_SAT  = 63'h4000_0000_0000_0000;
   localparam logic [DVD_W-1:0]  DELTA_NUM = 63'h0000_0100_0000_0000;

   localparam logic [3:0] OP_NONE        = 4'd0;
   localparam logic [3:0] OP_LOAD        = 4'd1;
   localparam logic [3:0] OP_DELTA_START = 4'd2;
   localparam logic [3:0] OP_DELTA_TAKE  = 4'd3;
   localparam logic [3:0] OP_SIDE_LO     = 4'd4;
   localparam logic [3:0] OP_SIDE_HI     = 4'd5;
   localparam logic [3:0] OP_SIDE_TAKE   = 4'd6;
   localparam logic [3:0] OP_STEP        = 4'd7;
   localparam logic [3:0] OP_HIT         = 4'd8;
   localparam logic [3:0] OP_FACE        = 4'd9;
   localparam logic [3:0] OP_ENTRY_LO    = 4'd10;
   localparam logic [3:0] OP_ENTRY_HI    = 4'd11;
   localparam logic [3:0] OP_ENTRY_DIV   = 4'd12;
   localparam logic [3:0] OP_ENTRY_TAKE  = 4'd13;
   localparam logic [3:0] OP_OUT         = 4'd14;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic       solid;
      logic [1:0] axis_last;
      logic [2:0] dir_zero;
   } stat_type;

   function automatic logic box_in(input logic signed [15:0] a,
                                   input logic signed [15:0] c,
                                   input logic signed [15:0] h);
      logic signed [15:0] s;
      s = a + c;
      return (s < h) && (s > -h);
   endfunction

   function automatic logic is_three(input logic signed [15:0] v);
      return (v == 16'sd3) || (v == -16'sd3);
   endfunction

   // Doubled coordinates so the cell centre 2m+1 is an integer.
   function automatic logic cell_solid(input logic signed [CELL_W-1:0] mx,
                                       input logic signed [CELL_W-1:0] my,
                                       input logic signed [CELL_W-1:0] mz);
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               b;
      logic               s;
      x = {{2{mx[CELL_W-1]}}, mx, 1'b1};
      y = {{2{my[CELL_W-1]}}, my, 1'b1};
      z = {{2{mz[CELL_W-1]}}, mz, 1'b1};
      b = (box_in(y, 16'sd12, 16'sd2) && box_in(x, -16'sd2, 16'sd4)
           && box_in(z, -16'sd8, 16'sd10))
        || (box_in(y, 16'sd8, 16'sd4) && box_in(x, -16'sd6, 16'sd4)
           && box_in(z, -16'sd12, 16'sd4))
        || (box_in(y, -16'sd8, 16'sd2) && box_in(x, 16'sd9, 16'sd3)
           && box_in(z, -16'sd10, 16'sd2))
        || (box_in(y, -16'sd1, 16'sd13) && box_in(x, -16'sd10, 16'sd4)
           && box_in(z, 16'sd3, 16'sd8))
        || (box_in(y, -16'sd8, 16'sd2) && box_in(x, -16'sd8, 16'sd2)
           && box_in(z, 16'sd6, 16'sd4))
        || (box_in(y, 16'sd2, 16'sd2) && box_in(x, -16'sd14, 16'sd4)
           && box_in(z, 16'sd8, 16'sd2));
      // Odd offsets below 5 are 1 or 3; only all three at 3 leave the sphere.
      s = box_in(x, 16'sd16, 16'sd5) && box_in(y, 16'sd0, 16'sd5)
        && box_in(z, 16'sd18, 16'sd5)
        && !(is_three(x + 16'sd16) && is_three(y) && is_three(z + 16'sd18));
      return b || s;
   endfunction

endpackage

FILE: rtl/core/voxel_ray_traversal_fixed_scene.sv
// Top level of the voxel ray traversal block against a fixed scene.
// One ray per command: start is taken when busy is low, and the result beat
// appears on the rsp_ ports for exactly one cycle under rsp_valid; the
// receiver cannot stall it. A ray's setup runs one 41-bit step-distance
// division per non-zero direction axis in the shared radix-2 divider, plus
// the side-distance multiply, then the walk visits one cell per cycle for up
// to STEP_LIMIT steps, then up to two 63-bit divisions in the same divider
// give the entry point. The run time is set by the one-bit-per-cycle divider
// and the one-cell-per-cycle walk. Start may be raised again in the cycle the
// result beat is shown.
module voxel_ray_traversal_fixed_scene #(
   parameter int STEP_LIMIT = vrt_pkg::STEP_LIMIT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_direction_x,
   input  logic signed [31:0] req_direction_y,
   input  logic signed [31:0] req_direction_z,
   output logic               rsp_valid,
   output logic               rsp_tile_hit,
   output logic [1:0]         rsp_face_axis,
   output logic signed [31:0] rsp_hit_x,
   output logic signed [31:0] rsp_hit_y,
   output logic signed [31:0] rsp_hit_z
);
   import vrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Controller: sequence the setup, the walk and the entry-point work.
   vrt_ctrl #(
      .STEP_LIMIT (STEP_LIMIT)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Datapath: hold the ray, advance the cells, drive the result beat.
   vrt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_origin_z    (req_origin_z),
      .req_direction_x (req_direction_x),
      .req_direction_y (req_direction_y),
      .req_direction_z (req_direction_z),
      .rsp_valid       (rsp_valid),
      .rsp_tile_hit    (rsp_tile_hit),
      .rsp_face_axis   (rsp_face_axis),
      .rsp_hit_x       (rsp_hit_x),
      .rsp_hit_y       (rsp_hit_y),
      .rsp_hit_z       (rsp_hit_z)
   );

`ifndef SYNTH
   // The result beat comes exactly when the block has just gone idle.
   a_beat_on_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result beat without end of work");

   a_idle_gives_beat: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("work ended without a result beat");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted ray did not make the block busy");

   a_no_axis_no_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_face_axis == 2'd0) |-> $past(!busy, 2) == 1'b0)
      else $error("result with no step came too early");
`endif

endmodule

FILE: rtl/core/vrt_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module vrt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        short_mode,
   input  logic [vrt_pkg::DVD_W-1:0]   dividend,
   input  logic [vrt_pkg::DVS_W-1:0]   divisor,
   output logic                        done,
   output logic [vrt_pkg::DVD_W-1:0]   quotient
);
   import vrt_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W:0]    trial;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         // A short dividend is left-aligned so only its 41 bits are walked.
         dvd_in = short_mode ? (dividend << (DVD_W - DELTA_W)) : dividend;
         cnt_in = short_mode ? 7'(DELTA_W) : 7'(DVD_W);
         quo_in = '0;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/vrt_dp.sv
// Traversal datapath: ray registers, walk step, multiplier, divider and result.
module vrt_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  vrt_pkg::cmd_type        cmd,
   output vrt_pkg::stat_type       stat,
   input  logic signed [31:0]      req_origin_x,
   input  logic signed [31:0]      req_origin_y,
   input  logic signed [31:0]      req_origin_z,
   input  logic signed [31:0]      req_direction_x,
   input  logic signed [31:0]      req_direction_y,
   input  logic signed [31:0]      req_direction_z,
   output logic                    rsp_valid,
   output logic                    rsp_tile_hit,
   output logic [1:0]              rsp_face_axis,
   output logic signed [31:0]      rsp_hit_x,
   output logic signed [31:0]      rsp_hit_y,
   output logic signed [31:0]      rsp_hit_z
);
   import vrt_pkg::*;

   logic signed [31:0]        org_ff   [3];
   logic signed [31:0]        dir_ff   [3];
   logic signed [CELL_W-1:0]  cell_ff  [3];
   logic [DELTA_W-1:0]        delta_ff [3];
   logic [SIDE_W-1:0]         side_ff  [3];
   logic signed [HIT_W-1:0]   hit_ff   [3];
   logic [PROD_W-1:0]         prod_ff;
   logic [DVD_W-1:0]          acc_ff;
   logic                      tile_ff;
   logic [1:0]                axis_ff;
   logic [DIFF_W-1:0]         diff_abs_ff;
   logic                      diff_neg_ff;
   logic [DVS_W-1:0]          den_abs_ff;
   logic                      den_neg_ff;
   logic                      valid_ff;
   logic                      out_tile_ff;
   logic [1:0]                out_axis_ff;
   logic signed [31:0]        out_x_ff, out_y_ff, out_z_ff;

   logic [1:0]                sel;
   logic [DVS_W-1:0]          dir_abs;
   logic [20:0]               frac;
   logic [31:0]               mul_a;
   logic [20:0]               mul_b;
   logic [PROD_W-1:0]         prod;
   logic [1:0]                ch;
   logic [SIDE_W-1:0]         side_next;
   logic signed [13:0]        face_cell;
   logic signed [34:0]        face;
   logic signed [34:0]        diff;
   logic [34:0]               diff_mag;
   logic                      div_start;
   logic                      div_done;
   logic [DVD_W-1:0]          div_dvd;
   logic [DVD_W-1:0]          quo;
   logic                      ent_neg;
   logic signed [HIT_W-1:0]   ent_off;

   assign sel     = cmd.sel;
   assign dir_abs = dir_ff[sel][31] ? DVS_W'(-dir_ff[sel]) : DVS_W'(dir_ff[sel]);
   // Distance to the first boundary along the step sign, Q.20.
   assign frac    = dir_ff[sel][31] ? {1'b0, org_ff[sel][19:0]}
                                    : 21'h10_0000 - {1'b0, org_ff[sel][19:0]};

   always_comb begin
      mul_a = {11'b0, delta_ff[sel][20:0]};
      mul_b = frac;
      case (cmd.op)
         OP_SIDE_HI:  begin
            mul_a = {12'b0, delta_ff[sel][DELTA_W-1:21]};
         end
         OP_ENTRY_LO: begin
            mul_a = {1'b0, diff_abs_ff};
            mul_b = {5'b0, dir_abs[15:0]};
         end
         OP_ENTRY_HI: begin
            mul_a = {1'b0, diff_abs_ff};
            mul_b = {5'b0, dir_abs[31:16]};
         end
         default: begin
         end
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Axis choice: x only if strictly lowest, then y if below z, else z.
   always_comb begin
      if (side_ff[0] < side_ff[1] && side_ff[0] < side_ff[2]) begin
         ch = 2'd0;
      end else if (side_ff[1] < side_ff[2]) begin
         ch = 2'd1;
      end else begin
         ch = 2'd2;
      end
      if (side_ff[ch] >= SIDE_SAT - SIDE_W'(delta_ff[ch])) begin
         side_next = SIDE_SAT;
      end else begin
         side_next = side_ff[ch] + SIDE_W'(delta_ff[ch]);
      end
   end

   assign face_cell = {cell_ff[sel][CELL_W-1], cell_ff[sel]}
                    + (dir_ff[sel][31] ? 14'sd1 : 14'sd0);
   assign face      = {face_cell[13], face_cell, 20'b0};
   assign diff      = face - {{3{org_ff[sel][31]}}, org_ff[sel]};
   assign diff_mag  = diff[34] ? 35'(-diff) : 35'(diff);

   assign div_start = (cmd.op == OP_DELTA_START) || (cmd.op == OP_ENTRY_DIV);
   assign div_dvd   = (cmd.op == OP_DELTA_START) ? DELTA_NUM
                    : acc_ff + (DVD_W'(prod_ff) << 16);

   vrt_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .short_mode (cmd.op == OP_DELTA_START),
      .dividend   (div_dvd),
      .divisor    ((cmd.op == OP_DELTA_START) ? dir_abs : den_abs_ff),
      .done       (div_done),
      .quotient   (quo)
   );

   assign ent_neg = diff_neg_ff ^ dir_ff[sel][31] ^ den_neg_ff;
   assign ent_off = ent_neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});

   function automatic logic signed [31:0] to_q16(input logic signed [HIT_W-1:0] v);
      logic signed [HIT_W-1:0] s;
      s = v >>> 4;
      if (s > 65'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (s < -65'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return s[31:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (cmd.op == OP_OUT);
      end
      case (cmd.op)
         OP_LOAD: begin
            org_ff[0] <= req_origin_x;
            org_ff[1] <= req_origin_y;
            org_ff[2] <= req_origin_z;
            dir_ff[0] <= req_direction_x;
            dir_ff[1] <= req_direction_y;
            dir_ff[2] <= req_direction_z;
            cell_ff[0] <= {req_origin_x[31], req_origin_x[31:20]};
            cell_ff[1] <= {req_origin_y[31], req_origin_y[31:20]};
            cell_ff[2] <= {req_origin_z[31], req_origin_z[31:20]};
            for (int k = 0; k < 3; k++) begin
               delta_ff[k] <= '0;
               side_ff[k]  <= SIDE_SAT;
            end
            tile_ff <= 1'b0;
            axis_ff <= 2'd0;
         end
         OP_DELTA_TAKE: delta_ff[sel] <= quo[DELTA_W-1:0];
         OP_SIDE_LO:    prod_ff <= prod;
         OP_SIDE_HI: begin
            acc_ff  <= DVD_W'(prod_ff);
            prod_ff <= prod;
         end
         OP_SIDE_TAKE: begin
            side_ff[sel] <= SIDE_W'((acc_ff + (DVD_W'(prod_ff) << 21)) >> 20);
         end
         OP_STEP: begin
            side_ff[ch] <= side_next;
            cell_ff[ch] <= cell_ff[ch] + (dir_ff[ch][31] ? -13'sd1 : 13'sd1);
            axis_ff     <= ch + 2'd1;
         end
         OP_HIT: tile_ff <= 1'b1;
         OP_FACE: begin
            for (int k = 0; k < 3; k++) begin
               if (axis_ff != 2'd0 && sel == 2'(k)) begin
                  hit_ff[k] <= {{(HIT_W-35){face[34]}}, face};
               end else begin
                  hit_ff[k] <= {{(HIT_W-32){org_ff[k][31]}}, org_ff[k]};
               end
            end
            diff_abs_ff <= diff_mag[DIFF_W-1:0];
            diff_neg_ff <= diff[34];
            den_abs_ff  <= dir_abs;
            den_neg_ff  <= dir_ff[sel][31];
         end
         OP_ENTRY_LO: prod_ff <= prod;
         OP_ENTRY_HI: begin
            acc_ff  <= DVD_W'(prod_ff);
            prod_ff <= prod;
         end
         OP_ENTRY_TAKE: begin
            hit_ff[sel] <= {{(HIT_W-32){org_ff[sel][31]}}, org_ff[sel]} + ent_off;
         end
         OP_OUT: begin
            out_tile_ff <= tile_ff;
            out_axis_ff <= axis_ff;
            out_x_ff    <= to_q16(hit_ff[0]);
            out_y_ff    <= to_q16(hit_ff[1]);
            out_z_ff    <= to_q16(hit_ff[2]);
         end
         default: begin
         end
      endcase
   end

   assign stat.div_done  = div_done;
   assign stat.solid     = cell_solid(cell_ff[0], cell_ff[1], cell_ff[2]);
   assign stat.axis_last = axis_ff;
   assign stat.dir_zero  = {dir_ff[2] == 32'sd0, dir_ff[1] == 32'sd0, dir_ff[0] == 32'sd0};

   assign rsp_valid     = valid_ff;
   assign rsp_tile_hit  = out_tile_ff;
   assign rsp_face_axis = out_axis_ff;
   assign rsp_hit_x     = out_x_ff;
   assign rsp_hit_y     = out_y_ff;
   assign rsp_hit_z     = out_z_ff;

endmodule

FILE: rtl/core/vrt_ctrl.sv
// Sequencer: setup divisions, cell walk, entry-point divisions, result beat.
module vrt_ctrl #(
   parameter int STEP_LIMIT = vrt_pkg::STEP_LIMIT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  vrt_pkg::stat_type  stat,
   output vrt_pkg::cmd_type   cmd,
   output logic               busy
);
   import vrt_pkg::*;

   localparam int CNT_W = $clog2(STEP_LIMIT + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DSTART = 4'd1;
   localparam logic [3:0] S_DWAIT  = 4'd2;
   localparam logic [3:0] S_SLO    = 4'd3;
   localparam logic [3:0] S_SHI    = 4'd4;
   localparam logic [3:0] S_STAKE  = 4'd5;
   localparam logic [3:0] S_WALK   = 4'd6;
   localparam logic [3:0] S_FACE   = 4'd7;
   localparam logic [3:0] S_ELO    = 4'd8;
   localparam logic [3:0] S_EHI    = 4'd9;
   localparam logic [3:0] S_EDIV   = 4'd10;
   localparam logic [3:0] S_EWAIT  = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       a;
   logic [2:0]       nk;

   assign a  = stat.axis_last - 2'd1;
   assign nk = ({1'b0, k_ff} + 3'd1 == {1'b0, a}) ? {1'b0, k_ff} + 3'd2
                                                 : {1'b0, k_ff} + 3'd1;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = k_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               k_in     = 2'd0;
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            if (stat.dir_zero[k_ff]) begin
               if (k_ff == 2'd2) begin
                  cnt_in   = '0;
                  state_in = S_WALK;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               cmd.op   = OP_DELTA_START;
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (stat.div_done) begin
               cmd.op   = OP_DELTA_TAKE;
               state_in = S_SLO;
            end
         end
         S_SLO: begin
            cmd.op   = OP_SIDE_LO;
            state_in = S_SHI;
         end
         S_SHI: begin
            cmd.op   = OP_SIDE_HI;
            state_in = S_STAKE;
         end
         S_STAKE: begin
            cmd.op = OP_SIDE_TAKE;
            if (k_ff == 2'd2) begin
               cnt_in   = '0;
               state_in = S_WALK;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_DSTART;
            end
         end
         S_WALK: begin
            // The cell entered by the last permitted step is not tested.
            if (cnt_ff == CNT_W'(STEP_LIMIT)) begin
               state_in = S_FACE;
            end else if (stat.solid) begin
               cmd.op   = OP_HIT;
               state_in = S_FACE;
            end else begin
               cmd.op = OP_STEP;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_FACE: begin
            cmd.op  = OP_FACE;
            cmd.sel = a;
            if (stat.axis_last == 2'd0 || stat.dir_zero[a]) begin
               state_in = S_OUT;
            end else begin
               k_in     = (a == 2'd0) ? 2'd1 : 2'd0;
               state_in = S_ELO;
            end
         end
         S_ELO: begin
            cmd.op   = OP_ENTRY_LO;
            state_in = S_EHI;
         end
         S_EHI: begin
            cmd.op   = OP_ENTRY_HI;
            state_in = S_EDIV;
         end
         S_EDIV: begin
            cmd.op   = OP_ENTRY_DIV;
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (stat.div_done) begin
               cmd.op = OP_ENTRY_TAKE;
               if (nk > 3'd2) begin
                  state_in = S_OUT;
               end else begin
                  k_in     = nk[1:0];
                  state_in = S_ELO;
               end
            end
         end
         S_OUT: begin
            cmd.op   = OP_OUT;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule
